// ===== src/sgr_pkg.sv =====
// sgr_pkg: shared constants, codes, types and helpers of the segmented group reduce block.
// No dependencies; used by sgr_mul, segmented_group_reduce and the bench.
`default_nettype none

package sgr_pkg;

   localparam int MAX_GROUPS = 1024;
   localparam int GROUP_W    = $clog2(MAX_GROUPS);
   localparam int CNT_W      = 11;                 // group_count register width
   localparam int DATA_W     = 64;
   localparam int HALF_W     = DATA_W / 2;

   localparam int OP_W       = 2;
   localparam int MODE_W     = 3;
   localparam int EW_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CNT_W;

   localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUM   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PROD  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ANY   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ALL   = 3'd4;

   localparam logic [EW_W-1:0] EW_8  = 2'd0;
   localparam logic [EW_W-1:0] EW_16 = 2'd1;
   localparam logic [EW_W-1:0] EW_32 = 2'd2;
   localparam logic [EW_W-1:0] EW_64 = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_COUNT;
   localparam logic [EW_W-1:0]   EW_RESET    = EW_64;
   localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_GROUPS);

   // start request to the iterative multiplier
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } mul_req_type;

   function automatic logic [DATA_W-1:0] width_mask(input logic [EW_W-1:0] ew);
      logic [DATA_W-1:0] m;
      case (ew)
         EW_8:    m = 64'h0000_0000_0000_00FF;
         EW_16:   m = 64'h0000_0000_0000_FFFF;
         EW_32:   m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== src/sgr_ram.sv =====
// sgr_ram: simple dual-port synchronous RAM, one write and one registered read port.
// Self-contained; read data holds while rd_en is low.
`default_nettype none

module sgr_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/sgr_mul.sv =====
// sgr_mul: low 64 bits of a 64x64 product from one shared 32x32 multiplier over three passes.
// Depends on sgr_pkg.
`default_nettype none

module sgr_mul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sgr_pkg::mul_req_type      req,
   output logic                           done,
   output logic [sgr_pkg::DATA_W-1:0]     product
);

   localparam int HW = sgr_pkg::HALF_W;

   // pass 0: a_lo*b_lo, pass 1: a_hi*b_lo, pass 2: a_lo*b_hi (cross terms shifted up)
   localparam logic [1:0] PASS_LL = 2'd0;
   localparam logic [1:0] PASS_HL = 2'd1;
   localparam logic [1:0] PASS_LH = 2'd2;

   logic [sgr_pkg::DATA_W-1:0] a_ff, b_ff;
   logic                       busy_ff, busy_in;
   logic [1:0]                 pass_ff, pass_in;
   logic                       prod_vld_ff;
   logic [1:0]                 prod_tag_ff;
   logic [sgr_pkg::DATA_W-1:0] prod_ff;
   logic [sgr_pkg::DATA_W-1:0] sum_ff, sum_in;
   logic                       done_ff, done_in;
   logic [HW-1:0]              mx, my;

   always_comb begin
      case (pass_ff)
         PASS_LL: begin
            mx = a_ff[HW-1:0];
            my = b_ff[HW-1:0];
         end
         PASS_HL: begin
            mx = a_ff[sgr_pkg::DATA_W-1:HW];
            my = b_ff[HW-1:0];
         end
         default: begin
            mx = a_ff[HW-1:0];
            my = b_ff[sgr_pkg::DATA_W-1:HW];
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pass_in = pass_ff;
      if (req.start) begin
         busy_in = 1'b1;
         pass_in = PASS_LL;
      end else if (busy_ff) begin
         pass_in = pass_ff + 2'd1;
         if (pass_ff == PASS_LH) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      done_in = 1'b0;
      if (req.start) begin
         sum_in = '0;
      end else if (prod_vld_ff) begin
         if (prod_tag_ff == PASS_LL) begin
            sum_in = sum_ff + prod_ff;
         end else begin
            sum_in = sum_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
         end
         done_in = (prod_tag_ff == PASS_LH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pass_ff     <= PASS_LL;
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         pass_ff     <= pass_in;
         prod_vld_ff <= busy_ff;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff <= req.a;
         b_ff <= req.b;
      end
      prod_ff     <= {{HW{1'b0}}, mx} * {{HW{1'b0}}, my};
      prod_tag_ff <= pass_ff;
      sum_ff      <= sum_in;
   end

   assign done    = done_ff;
   assign product = sum_ff;

endmodule

`default_nettype wire

// ===== src/segmented_group_reduce.sv =====
// segmented_group_reduce: top level, control sequencer around the accumulator RAM and multiplier.
// Depends on sgr_pkg, sgr_ram and sgr_mul.
`default_nettype none

// Per-group accumulator store for segmented reductions. Each request transfer
// carries an op: accumulate folds req_value into the accumulator of req_group
// (count, wrapping sum, wrapping product, any-nonzero or all-nonzero, chosen by
// reduce_mode and wrapped or masked at element_width), read returns one
// response transfer with the masked accumulator (0 or 1 in any/all mode), and
// clear writes the mode's identity into every group below group_count. The
// accumulators live in a 1024 x 64 synchronous RAM; one request is in flight at
// a time. An accumulate reads the RAM entry, then modifies it and writes it
// back; a read waits after the RAM read while the response register is still
// occupied; accumulate in product mode builds the 64-bit product from three
// passes through a single 32x32 multiplier; and clear sweeps the RAM one entry
// per cycle over the groups in use. After reset the block zeroes all 1024 RAM
// entries in a sweep during which req_ready stays low; register writes are
// taken at any time. Registers are written through csr_we/csr_index/csr_wdata
// (0 mode, 1 element width, 2 group count) and should only change while the
// block is idle.

module segmented_group_reduce (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             csr_we,
   input  wire logic [sgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sgr_pkg::CSR_DATA_W-1:0]   csr_wdata,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [sgr_pkg::OP_W-1:0]         req_op,
   input  wire logic [sgr_pkg::GROUP_W-1:0]      req_group,
   input  wire logic [sgr_pkg::DATA_W-1:0]       req_value,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [sgr_pkg::GROUP_W-1:0]           rsp_result_group,
   output logic [sgr_pkg::DATA_W-1:0]            rsp_result_value,
   output logic                                  rsp_out_of_range
);

   localparam int GW = sgr_pkg::GROUP_W;
   localparam int CW = sgr_pkg::CNT_W;
   localparam int DW = sgr_pkg::DATA_W;

   // sequencer states
   localparam logic [2:0] ST_INIT  = 3'd0;   // power-on zeroing sweep
   localparam logic [2:0] ST_IDLE  = 3'd1;   // waiting for a request transfer
   localparam logic [2:0] ST_EXEC  = 3'd2;   // RAM data back, modify / respond
   localparam logic [2:0] ST_MUL   = 3'd3;   // waiting on the multiplier
   localparam logic [2:0] ST_SWEEP = 3'd4;   // clear sweep

   // ---------------------------------------------------------------- registers
   logic [sgr_pkg::MODE_W-1:0] mode_ff;
   logic [sgr_pkg::EW_W-1:0]   ew_ff;
   logic [CW-1:0]              gcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sgr_pkg::MODE_RESET;
         ew_ff     <= sgr_pkg::EW_RESET;
         gcount_ff <= sgr_pkg::COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sgr_pkg::CSR_MODE:  mode_ff   <= csr_wdata[sgr_pkg::MODE_W-1:0];
            sgr_pkg::CSR_WIDTH: ew_ff     <= csr_wdata[sgr_pkg::EW_W-1:0];
            sgr_pkg::CSR_COUNT: gcount_ff <= csr_wdata[CW-1:0];
            default: ;   // no register at this index
         endcase
      end
   end

   logic [DW-1:0] mask;
   logic [CW-1:0] in_use;    // min(group_count, MAX_GROUPS)
   logic [DW-1:0] identity;

   assign mask   = sgr_pkg::width_mask(ew_ff);
   assign in_use = (gcount_ff > CW'(sgr_pkg::MAX_GROUPS)) ? CW'(sgr_pkg::MAX_GROUPS)
                                                          : gcount_ff;
   assign identity = ((mode_ff == sgr_pkg::MODE_PROD) || (mode_ff == sgr_pkg::MODE_ALL))
                     ? DW'(1) : DW'(0);

   // ---------------------------------------------------------------- state
   logic [2:0]               state_ff, state_in;
   logic [CW-1:0]            sweep_ptr_ff, sweep_ptr_in;
   logic [CW-1:0]            sweep_end_ff, sweep_end_in;
   logic [DW-1:0]            sweep_val_ff, sweep_val_in;

   // request held for the duration of the operation (payload, no reset)
   logic [sgr_pkg::OP_W-1:0] op_ff;
   logic [GW-1:0]            group_ff;
   logic [DW-1:0]            value_ff;   // already masked to element width
   logic                     in_range_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]            rsp_group_ff;
   logic [DW-1:0]            rsp_value_ff;
   logic                     rsp_oor_ff;
   logic                     rsp_load;
   logic [DW-1:0]            rsp_value_in;

   logic                     accept;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- RAM
   logic          ram_we;
   logic [GW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [DW-1:0] ram_rdata;

   sgr_ram #(
      .DEPTH (sgr_pkg::MAX_GROUPS),
      .WIDTH (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_group),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- multiplier
   sgr_pkg::mul_req_type mul_req;
   logic                 mul_done;
   logic [DW-1:0]        mul_product;

   sgr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   // ---------------------------------------------------------------- datapath
   logic          acc_we;
   logic [DW-1:0] acc_new;
   logic          acc_mul;
   logic [DW-1:0] acc_masked;

   assign acc_masked = ram_rdata & mask;

   // combinational combine step for every mode but product, which hands off to the multiplier
   always_comb begin
      acc_we  = 1'b0;
      acc_mul = 1'b0;
      acc_new = ram_rdata;
      case (mode_ff)
         sgr_pkg::MODE_COUNT: begin
            acc_we  = 1'b1;
            acc_new = ram_rdata + DW'(1);   // full-width counter, masked on read
         end
         sgr_pkg::MODE_SUM: begin
            acc_we  = 1'b1;
            acc_new = (ram_rdata + value_ff) & mask;
         end
         sgr_pkg::MODE_PROD: begin
            acc_mul = 1'b1;
         end
         sgr_pkg::MODE_ANY: begin
            acc_we  = 1'b1;
            acc_new = DW'((|acc_masked) || (|value_ff));
         end
         sgr_pkg::MODE_ALL: begin
            acc_we  = 1'b1;
            acc_new = DW'((|acc_masked) && (|value_ff));
         end
         default: ;   // undefined mode: accumulate dropped
      endcase
   end

   // read response value
   always_comb begin
      if (!in_range_ff) begin
         rsp_value_in = '0;
      end else if ((mode_ff == sgr_pkg::MODE_ANY) || (mode_ff == sgr_pkg::MODE_ALL)) begin
         rsp_value_in = DW'(|acc_masked);
      end else begin
         rsp_value_in = acc_masked;
      end
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_ptr_in  = sweep_ptr_ff;
      sweep_end_in  = sweep_end_ff;
      sweep_val_in  = sweep_val_ff;
      ram_we        = 1'b0;
      ram_waddr     = group_ff;
      ram_wdata     = acc_new;
      mul_req.start = 1'b0;
      mul_req.a     = ram_rdata;
      mul_req.b     = value_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_INIT, ST_SWEEP: begin
            ram_we       = 1'b1;
            ram_waddr    = sweep_ptr_ff[GW-1:0];
            ram_wdata    = sweep_val_ff;
            sweep_ptr_in = sweep_ptr_ff + CW'(1);
            if ((sweep_ptr_ff + CW'(1)) == sweep_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               sgr_pkg::OP_ACC: begin
                  if (in_range_ff && acc_mul) begin
                     mul_req.start = 1'b1;
                     state_in      = ST_MUL;
                  end else begin
                     ram_we   = in_range_ff && acc_we;
                     state_in = ST_IDLE;
                  end
               end
               sgr_pkg::OP_READ: begin
                  // hold here until the response register can take the result
                  if (rsp_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               sgr_pkg::OP_CLEAR: begin
                  sweep_ptr_in = '0;
                  sweep_end_in = in_use;
                  sweep_val_in = identity;
                  state_in     = (in_use == '0) ? ST_IDLE : ST_SWEEP;
               end
               default: begin
                  state_in = ST_IDLE;   // unused op code: no effect
               end
            endcase
         end
         ST_MUL: begin
            ram_wdata = mul_product & mask;
            if (mul_done) begin
               ram_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ptr_ff <= '0;
         sweep_end_ff <= CW'(sgr_pkg::MAX_GROUPS);
         sweep_val_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ptr_ff <= sweep_ptr_in;
         sweep_end_ff <= sweep_end_in;
         sweep_val_ff <= sweep_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         group_ff    <= req_group;
         value_ff    <= req_value & mask;
         in_range_ff <= ({1'b0, req_group} < in_use);
      end
      if (rsp_load) begin
         rsp_group_ff <= group_ff;
         rsp_value_ff <= rsp_value_in;
         rsp_oor_ff   <= !in_range_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_group = rsp_group_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_segmented_group_reduce.sv =====
// tb_segmented_group_reduce: self-checking bench for the segmented group reduce block.
// Depends on sgr_pkg and segmented_group_reduce; keeps its own model of the accumulator store.
`default_nettype none

module tb_segmented_group_reduce;

   import sgr_pkg::*;

   // codes that the package leaves unnamed
   localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;  // undefined op, must be ignored
   localparam logic [MODE_W-1:0] MODE_SPARE  = 3'd5;  // undefined modes 5..7
   localparam logic [MODE_W-1:0] MODE_SPARE2 = 3'd7;

   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 160;
   // worst case busy time with no response: a clear over 1024 groups plus margin
   localparam int SETTLE_CYCLES = 1100;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [GROUP_W-1:0] group;
      logic [DATA_W-1:0]  value;
      logic               hold;    // wait for every read result before presenting
   } req_item_type;

   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [DATA_W-1:0]  value;
      logic               oor;
   } read_result_type;

   // ---------------------------------------------------------------------------
   // clock, reset and DUT ports; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op    = '0;
   logic [GROUP_W-1:0]    req_group = '0;
   logic [DATA_W-1:0]     req_value = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [GROUP_W-1:0]    rsp_result_group;
   logic [DATA_W-1:0]     rsp_result_value;
   logic                  rsp_out_of_range;

   segmented_group_reduce uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_group        (req_group),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_group (rsp_result_group),
      .rsp_result_value (rsp_result_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // bench state
   // ---------------------------------------------------------------------------
   req_item_type    request_backlog[$];   // items waiting to be offered
   read_result_type read_results_due[$];  // predicted read results, oldest first

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned queued_cnt     = 0;
   int unsigned accepted_cnt   = 0;
   int unsigned mismatch_cnt   = 0;
   int unsigned checked_cnt    = 0;
   int unsigned acc_cnt        = 0;
   int unsigned read_cnt       = 0;
   int unsigned clear_cnt      = 0;
   int unsigned settings_cnt   = 0;

   // ---------------------------------------------------------------------------
   // model of the accumulator store, with its own copy of the registers
   // ---------------------------------------------------------------------------
   logic [DATA_W-1:0] acc_mem[MAX_GROUPS];
   logic [MODE_W-1:0] cfg_mode   = MODE_COUNT;
   logic [EW_W-1:0]   cfg_width  = EW_64;
   logic [CNT_W-1:0]  cfg_groups = CNT_W'(MAX_GROUPS);

   initial begin
      foreach (acc_mem[i]) acc_mem[i] = '0;
   end

   function automatic logic [DATA_W-1:0] elem_mask(input logic [EW_W-1:0] ew);
      return {DATA_W{1'b1}} >> (DATA_W - (8 << ew));
   endfunction

   function automatic int unsigned groups_in_use();
      return (cfg_groups > MAX_GROUPS) ? MAX_GROUPS : int'(cfg_groups);
   endfunction

   // fold one accepted item into the model; reads queue their result
   function automatic void apply_request(input req_item_type it);
      logic [DATA_W-1:0] m;
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] a;
      int unsigned       n;
      read_result_type   r;
      m = elem_mask(cfg_width);
      v = it.value & m;
      n = groups_in_use();
      case (it.op)
         OP_ACC: begin
            acc_cnt++;
            if (it.group < n) begin
               a = acc_mem[it.group];
               case (cfg_mode)
                  MODE_COUNT: acc_mem[it.group] = a + 64'd1;
                  MODE_SUM:   acc_mem[it.group] = (a + v) & m;
                  MODE_PROD:  acc_mem[it.group] = (a * v) & m;
                  MODE_ANY:   acc_mem[it.group] = ((a & m) != 0 || v != 0) ? 64'd1 : 64'd0;
                  MODE_ALL:   acc_mem[it.group] = ((a & m) != 0 && v != 0) ? 64'd1 : 64'd0;
                  default:    ;  // undefined mode: dropped
               endcase
            end
         end
         OP_READ: begin
            read_cnt++;
            r.group = it.group;
            r.value = '0;
            r.oor   = 1'b1;
            if (it.group < n) begin
               r.value = acc_mem[it.group] & m;
               if (cfg_mode == MODE_ANY || cfg_mode == MODE_ALL)
                  r.value = (r.value != 0) ? 64'd1 : 64'd0;
               r.oor = 1'b0;
            end
            read_results_due.push_back(r);
         end
         OP_CLEAR: begin
            clear_cnt++;
            for (int unsigned i = 0; i < n; i++)
               acc_mem[i] = (cfg_mode == MODE_PROD || cfg_mode == MODE_ALL) ? 64'd1 : 64'd0;
         end
         default: ;  // spare op: ignored
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: offers backlog items, predicts each one on its transfer
   // ---------------------------------------------------------------------------
   req_item_type cur_item = '0;

   always @(posedge clock) begin : req_drive
      bit present;
      present = req_valid;
      if (reset) begin
         present = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_request(cur_item);
            accepted_cnt++;
            present = 1'b0;
         end
         // a held item waits until every predicted read result has come back
         if (!present && request_backlog.size() > 0 &&
             $urandom_range(99) >= send_idle_pct &&
             !(request_backlog[0].hold && read_results_due.size() != 0)) begin
            cur_item = request_backlog.pop_front();
            present  = 1'b1;
         end
      end
      req_valid <= present;
      req_op    <= cur_item.op;
      req_group <= cur_item.group;
      req_value <= cur_item.value;
   end

   // ---------------------------------------------------------------------------
   // response monitor: random back-pressure, checks each transfer in order
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      read_result_type want;
      read_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_result_group, rsp_result_value, rsp_out_of_range};
         if (read_results_due.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
               $display("%0t: response with nothing due: group %0d value %h oor %b",
                        $realtime, got.group, got.value, got.oor);
         end else begin
            want = read_results_due.pop_front();
            checked_cnt++;
            if (got.group != want.group || got.value != want.value || got.oor != want.oor) begin
               mismatch_cnt++;
               if (mismatch_cnt <= REPORT_LIMIT)
                  $display("%0t: read mismatch: want group %0d value %h oor %b, got %0d %h %b",
                           $realtime, want.group, want.value, want.oor,
                           got.group, got.value, got.oor);
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void queue_item(input logic [OP_W-1:0] op, input int unsigned grp,
                                      input logic [DATA_W-1:0] val, input bit hold = 1'b0);
      req_item_type it;
      it.op    = op;
      it.group = GROUP_W'(grp);
      it.value = val;
      it.hold  = hold;
      request_backlog.push_back(it);
      queued_cnt++;
   endfunction

   // idle means every queued item transferred and every read answered; then
   // allow for a clear sweep that gives no response
   task automatic wait_idle();
      while (accepted_cnt != queued_cnt || read_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MODE:  cfg_mode   = data[MODE_W-1:0];
         CSR_WIDTH: cfg_width  = data[EW_W-1:0];
         CSR_COUNT: cfg_groups = data[CNT_W-1:0];
         default:   ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [MODE_W-1:0] mode, input logic [EW_W-1:0] ew,
                             input int unsigned count);
      write_csr(CSR_MODE, CSR_DATA_W'(mode));
      write_csr(CSR_WIDTH, CSR_DATA_W'(ew));
      write_csr(CSR_COUNT, CSR_DATA_W'(count));
      settings_cnt++;
   endtask

   // mix of zero, one, all-ones, small and full-width values; odd values
   // keep products from collapsing to zero
   function automatic logic [DATA_W-1:0] pick_value();
      int unsigned sel;
      logic [DATA_W-1:0] v;
      sel = $urandom_range(99);
      if (sel < 12)      v = '0;
      else if (sel < 22) v = '1;
      else if (sel < 32) v = 64'd1;
      else if (sel < 60) v = DATA_W'($urandom_range(15));
      else               v = {$urandom, $urandom};
      if (cfg_mode == MODE_PROD && $urandom_range(99) < 70)
         v[0] = 1'b1;
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [MODE_W-1:0] mode;
      logic [EW_W-1:0]   ew;
      int unsigned       count;
      int unsigned       n;
      int unsigned       sel;
      int unsigned       clear_span;
      int unsigned       grp;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings are count mode, 64-bit, all 1024 groups
      queue_item(OP_READ, 0, '0);
      queue_item(OP_READ, MAX_GROUPS - 1, '0);
      queue_item(OP_ACC, 0, '0);
      queue_item(OP_ACC, MAX_GROUPS - 1, '1);
      queue_item(OP_ACC, MAX_GROUPS - 1, 64'd1);
      queue_item(OP_READ, 0, '0);
      queue_item(OP_READ, MAX_GROUPS - 1, '0);
      queue_item(OP_SPARE, 5, '1);             // spare op leaves group 5 alone
      queue_item(OP_READ, 5, '1);
      wait_idle();

      // narrow sum wraps at 8 bits; accumulate beyond the count is dropped
      set_config(MODE_SUM, EW_8, 4);
      queue_item(OP_CLEAR, 0, '0);
      queue_item(OP_ACC, 3, 64'hFF);
      queue_item(OP_ACC, 3, 64'h102);
      queue_item(OP_ACC, 4, 64'd7);
      queue_item(OP_READ, 3, '0);
      queue_item(OP_READ, 4, '0);
      wait_idle();

      // count above the store size clamps to 1024 groups
      set_config(MODE_PROD, EW_16, 2047);
      queue_item(OP_CLEAR, 0, '0);
      queue_item(OP_ACC, MAX_GROUPS - 1, 64'hFFFF);
      queue_item(OP_ACC, MAX_GROUPS - 1, 64'h1_FFFF);
      queue_item(OP_READ, MAX_GROUPS - 1, '0);
      wait_idle();

      // no group in use at all
      set_config(MODE_ANY, EW_32, 0);
      queue_item(OP_CLEAR, 0, '0);
      queue_item(OP_ACC, 0, 64'd1);
      queue_item(OP_READ, 0, '0);
      wait_idle();

      // all-nonzero only sees the masked value
      set_config(MODE_ALL, EW_32, 3);
      queue_item(OP_CLEAR, 0, '0);
      queue_item(OP_ACC, 1, 64'h1_0000_0000);
      queue_item(OP_READ, 1, '0);
      wait_idle();

      // undefined mode: stored words read unconverted, accumulate dropped, clear writes zero
      set_config(MODE_SPARE, EW_64, 3);
      queue_item(OP_ACC, 2, 64'd5);
      queue_item(OP_READ, 2, '0);
      queue_item(OP_CLEAR, 0, '0);
      queue_item(OP_READ, 2, '0);
      wait_idle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_SPARE2));
      queue_item(OP_READ, 1, '0);
      wait_idle();

      // random phases: mostly well-formed clear/accumulate/read runs inside
      // the groups in use, with some noise on top
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin mode = MODE_COUNT; ew = EW_8;  count = 16;   end
            1:       begin mode = MODE_SUM;   ew = EW_64; count = 8;    end
            2:       begin mode = MODE_PROD;  ew = EW_8;  count = 12;   end
            3:       begin mode = MODE_ANY;   ew = EW_16; count = 32;   end
            4:       begin mode = MODE_ALL;   ew = EW_32; count = 5;    end
            5:       begin mode = MODE_SUM;   ew = EW_16; count = 1;    end
            6:       begin mode = MODE_PROD;  ew = EW_64; count = 1024; end
            7:       begin mode = MODE_COUNT; ew = EW_32; count = 2047; end
            8:       begin mode = MODE_ALL;   ew = EW_8;  count = 64;   end
            9:       begin mode = MODE_ANY;   ew = EW_64; count = 3;    end
            10:      begin mode = MODE_SUM;   ew = EW_32; count = $urandom_range(100, 1); end
            default: begin mode = MODE_PROD;  ew = EW_16; count = $urandom_range(40, 1);  end
         endcase
         case (p % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 19; rsp_stall_pct = 19; end
         endcase
         set_config(mode, ew, count);
         n = groups_in_use();
         clear_span = (n > 64) ? 5 : 30;

         // phase 9 keeps the words left by the all-nonzero phase
         if (p != 9)
            queue_item(OP_CLEAR, 0, '0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            sel = $urandom_range(999);
            grp = (n > 0) ? $urandom_range(n - 1) : $urandom_range(MAX_GROUPS - 1);
            if (sel < 550)
               queue_item(OP_ACC, grp, pick_value(), i == PHASE_ITEMS / 2);
            else if (sel < 900)
               queue_item(OP_READ, grp, pick_value(), i == PHASE_ITEMS / 2);
            else if (sel < 900 + clear_span)
               queue_item(OP_CLEAR, grp, pick_value(), i == PHASE_ITEMS / 2);
            else
               queue_item(OP_W'($urandom_range(3)), $urandom_range(MAX_GROUPS - 1),
                          {$urandom, $urandom}, $urandom_range(99) < 5);
         end
         wait_idle();
      end

      $display("covered %0d transfers in %0d register settings: %0d accumulates, %0d reads,",
               accepted_cnt, settings_cnt + 1, acc_cnt, read_cnt);
      $display("%0d clears; %0d read results checked, %0d mismatches",
               clear_cnt, checked_cnt, mismatch_cnt);
      if (mismatch_cnt == 0 && read_results_due.size() == 0) begin
         $display("tb_segmented_group_reduce: done, clean");
      end else begin
         $display("tb_segmented_group_reduce: done, errors");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #20_000_000;
      $display("timeout after %0d of %0d transfers, %0d results due",
               accepted_cnt, queued_cnt, read_results_due.size());
      $display("tb_segmented_group_reduce: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
